// ----- rtl/core/bba_pkg.sv -----
// shared types and constants for the bounding box accumulator
package bba_pkg;

  localparam int COORD_W  = 24;
  localparam int AXES     = 3;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int ROOT_W   = COORD_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int STEP_W   = $clog2(ROOT_W + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        ucoord_t;
  typedef logic [SQ_W-1:0]           sq_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
    logic   group_end;
  } item_t;

  typedef struct packed {
    coord_t  center_x;
    coord_t  center_y;
    coord_t  center_z;
    ucoord_t half_x;
    ucoord_t half_y;
    ucoord_t half_z;
    ucoord_t radius;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

  typedef enum logic [1:0] {
    FIN_IDLE,
    FIN_MERGE,
    FIN_ROOT,
    FIN_DRAIN
  } fin_state_t;

endpackage

// ----- rtl/core/bounding_box_accumulator_unit.sv -----
// top level: 3d axis-aligned bounding box accumulator
// path from the accepted group_end beat to the result beat: half-extent register, square,
//   sum, root load, one root step per root bit, drain and output register
// throughput: one item beat per cycle inside a group; a group_end beat is stalled until
//   the previous result is loaded into the output register
// reset: clears group_open, the sequencer, the merge and root valids and result_valid
module bounding_box_accumulator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bba_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output bba_pkg::result_t result
);

  // input side
  logic            take;
  logic            group_open;
  bba_pkg::coord_t lo_in   [bba_pkg::AXES];
  bba_pkg::coord_t hi_in   [bba_pkg::AXES];
  bba_pkg::coord_t min_nxt [bba_pkg::AXES];
  bba_pkg::coord_t max_nxt [bba_pkg::AXES];

  // finishing path
  bba_pkg::fin_state_t fin_state;
  bba_pkg::fin_state_t fin_state_next;
  logic                merge_start;
  bba_pkg::coord_t     center [bba_pkg::AXES];
  bba_pkg::ucoord_t    half   [bba_pkg::AXES];
  bba_pkg::sq_t        sum;
  logic                sum_valid;
  bba_pkg::ucoord_t    root;
  bba_pkg::root_stat_t root_stat;
  logic                load_result;

  // a group_end beat waits only while the finisher is still busy
  assign item_stall  = (fin_state != bba_pkg::FIN_IDLE) && item.group_end;
  assign take        = item_valid && !item_stall;
  assign merge_start = take && item.group_end;

  assign lo_in[0] = item.lo_x;
  assign lo_in[1] = item.lo_y;
  assign lo_in[2] = item.lo_z;
  assign hi_in[0] = item.hi_x;
  assign hi_in[1] = item.hi_y;
  assign hi_in[2] = item.hi_z;

  // one lane per axis
  for (genvar g = 0; g < bba_pkg::AXES; g++) begin : g_lane
    bba_lane u_lane (
      .clk      (clk),
      .a        (lo_in[g]),
      .b        (hi_in[g]),
      .open     (group_open),
      .take     (take),
      .min_next (min_nxt[g]),
      .max_next (max_nxt[g])
    );
  end

  // group_end closes the group; any other beat leaves it open
  always_ff @(posedge clk) begin
    if (rst) begin
      group_open <= 1'b0;
    end else if (take) begin
      group_open <= !item.group_end;
    end
  end

  // merge: the lanes' bounds including the closing beat feed the merge directly
  bba_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (merge_start),
    .mins      (min_nxt),
    .maxs      (max_nxt),
    .center    (center),
    .half      (half),
    .sum       (sum),
    .sum_valid (sum_valid)
  );

  bba_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sum_valid),
    .radicand (sum),
    .root     (root),
    .stat     (root_stat)
  );

  // finishing sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_state <= bba_pkg::FIN_IDLE;
    end else begin
      fin_state <= fin_state_next;
    end
  end

  always_comb begin
    fin_state_next = fin_state;
    load_result    = 1'b0;
    case (fin_state)
      bba_pkg::FIN_IDLE: begin
        if (merge_start) fin_state_next = bba_pkg::FIN_MERGE;
      end
      bba_pkg::FIN_MERGE: begin
        if (sum_valid) fin_state_next = bba_pkg::FIN_ROOT;
      end
      bba_pkg::FIN_ROOT: begin
        if (root_stat.done) fin_state_next = bba_pkg::FIN_DRAIN;
      end
      bba_pkg::FIN_DRAIN: begin
        // output register free or emptying this cycle
        if (!result_valid || !result_stall) begin
          load_result    = 1'b1;
          fin_state_next = bba_pkg::FIN_IDLE;
        end
      end
      default: begin
        fin_state_next = bba_pkg::FIN_IDLE;
      end
    endcase
  end

  // output register: parts the finisher from the result consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.center_x <= center[0];
      result.center_y <= center[1];
      result.center_z <= center[2];
      result.half_x   <= half[0];
      result.half_y   <= half[1];
      result.half_z   <= half[2];
      result.radius   <= root;
    end
  end

endmodule

// ----- rtl/core/bba_lane.sv -----
// one axis lane: sorts the corners and tracks the running min and max
module bba_lane (
  input  logic           clk,
  input  bba_pkg::coord_t a,
  input  bba_pkg::coord_t b,
  input  logic           open,
  input  logic           take,
  output bba_pkg::coord_t min_next,
  output bba_pkg::coord_t max_next
);

  bba_pkg::coord_t mn;
  bba_pkg::coord_t mx;
  bba_pkg::coord_t lo;
  bba_pkg::coord_t hi;

  always_comb begin
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    min_next = (open && (mn < lo)) ? mn : lo;
    max_next = (open && (mx > hi)) ? mx : hi;
  end

  // bounds need no reset: the first beat of a group loads them
  always_ff @(posedge clk) begin
    if (take) begin
      mn <= min_next;
      mx <= max_next;
    end
  end

endmodule

// ----- rtl/core/bba_merge.sv -----
// merge stage: center and half extent per axis, then squares and their sum
module bba_merge (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bba_pkg::coord_t mins [bba_pkg::AXES],
  input  bba_pkg::coord_t maxs [bba_pkg::AXES],
  output bba_pkg::coord_t center [bba_pkg::AXES],
  output bba_pkg::ucoord_t half [bba_pkg::AXES],
  output bba_pkg::sq_t    sum,
  output logic            sum_valid
);

  logic                        sq_valid;
  logic                        half_valid;
  bba_pkg::sq_t                sq [bba_pkg::AXES];
  logic signed [bba_pkg::COORD_W:0] pair_sum [bba_pkg::AXES];
  logic signed [bba_pkg::COORD_W:0] span     [bba_pkg::AXES];
  bba_pkg::coord_t             center_next [bba_pkg::AXES];

  always_comb begin
    for (int i = 0; i < bba_pkg::AXES; i++) begin
      pair_sum[i]    = {maxs[i][bba_pkg::COORD_W-1], maxs[i]}
                     + {mins[i][bba_pkg::COORD_W-1], mins[i]};
      // arithmetic shift of the sum gives the floor of the half sum
      center_next[i] = pair_sum[i][bba_pkg::COORD_W:1];
      span[i]        = {maxs[i][bba_pkg::COORD_W-1], maxs[i]}
                     - {center_next[i][bba_pkg::COORD_W-1], center_next[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_valid <= 1'b0;
      sq_valid   <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      half_valid <= start;
      sq_valid   <= half_valid;
      sum_valid  <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < bba_pkg::AXES; i++) begin
        center[i] <= center_next[i];
        half[i]   <= span[i][bba_pkg::COORD_W-1:0];
      end
    end
    if (half_valid) begin
      for (int i = 0; i < bba_pkg::AXES; i++) begin
        sq[i] <= bba_pkg::sq_t'(half[i]) * bba_pkg::sq_t'(half[i]);
      end
    end
    if (sq_valid) begin
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

endmodule

// ----- rtl/core/bba_sqrt.sv -----
// iterative integer square root, one result bit per cycle
module bba_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bba_pkg::sq_t        radicand,
  output bba_pkg::ucoord_t    root,
  output bba_pkg::root_stat_t stat
);

  bba_pkg::sq_t                      rad;
  logic [bba_pkg::REM_W-1:0]         rem;
  logic [bba_pkg::STEP_W-1:0]        cnt;
  logic [bba_pkg::REM_W-1:0]         rem_sh;
  logic [bba_pkg::REM_W-1:0]         trial;
  logic                              fits;
  logic                              done;

  always_comb begin
    rem_sh = {rem[bba_pkg::REM_W-3:0], rad[bba_pkg::SQ_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  assign stat = '{busy: (cnt != '0), done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= bba_pkg::STEP_W'(bba_pkg::ROOT_W);
      end else if (cnt != '0) begin
        cnt <= cnt - bba_pkg::STEP_W'(1);
        if (cnt == bba_pkg::STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= {rad[bba_pkg::SQ_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[bba_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule
